// File: sv/ysc_pkg.sv
// ysc_pkg: shared types and constants for the ymodem sender controller
// used by ysc_blk_plan and ymodem_sender_controller, depends on nothing

`default_nettype none

package ysc_pkg;

  localparam int OFF_W     = 24;
  localparam int LEN_W     = 11;
  localparam int BLK_W     = 8;
  localparam int LIMIT_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;

  localparam logic [LEN_W-1:0] LONG_BLOCK_BYTES  = LEN_W'(1024);
  localparam logic [LEN_W-1:0] SHORT_BLOCK_BYTES = LEN_W'(128);
  localparam logic [BLK_W-1:0] FIRST_BLOCK       = BLK_W'(8'h01);
  localparam logic [LIMIT_W-1:0] DEFAULT_TIMEOUT = LIMIT_W'(15);

  localparam logic [7:0] BYTE_C   = 8'h43;
  localparam logic [7:0] BYTE_ACK = 8'h06;
  localparam logic [7:0] BYTE_NAK = 8'h15;
  localparam logic [7:0] BYTE_CAN = 8'h18;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_XFER_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd2;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_HEADER    = 3'd1,
    ACT_DATA      = 3'd2,
    ACT_EOT       = 3'd3,
    ACT_NULL_PKT  = 3'd4,
    ACT_DONE      = 3'd5,
    ACT_CANCELLED = 3'd6,
    ACT_GAVE_UP   = 3'd7
  } action_t;

  typedef struct packed {
    logic [BLK_W-1:0] blk_num;
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
    logic             long_frame;
    logic [OFF_W-1:0] nxt_offset;
    logic [BLK_W-1:0] nxt_block;
  } blk_plan_t;

endpackage

`default_nettype wire

// File: sv/ysc_blk_plan.sv
// ysc_blk_plan: works out the next data block (number, offset, length, frame)
// for a fresh send or a resend; depends on ysc_pkg

`default_nettype none

module ysc_blk_plan (
  input  wire logic                      resend,
  input  wire logic [ysc_pkg::OFF_W-1:0] xfer_len,
  input  wire logic [ysc_pkg::OFF_W-1:0] next_offset,
  input  wire logic [ysc_pkg::OFF_W-1:0] last_offset,
  input  wire logic [ysc_pkg::BLK_W-1:0] next_block,
  output ysc_pkg::blk_plan_t             plan
);
  import ysc_pkg::*;

  logic [OFF_W-1:0] off;
  logic [BLK_W-1:0] blk;
  logic [OFF_W:0]   rem;
  logic             fs_gt;
  logic             rem_big;
  logic [OFF_W-1:0] off_long;
  logic [LEN_W-1:0] len;
  logic             first_send;

  assign first_send = (next_block == FIRST_BLOCK) && (next_offset == '0);
  assign off = resend ? last_offset : next_offset;
  assign blk = (resend && !first_send) ? next_block - BLK_W'(1) : next_block;

  assign rem      = {1'b0, xfer_len} - {1'b0, off};
  assign fs_gt    = !rem[OFF_W] && (rem[OFF_W-1:0] != '0);
  assign rem_big  = rem[OFF_W-1:0] > OFF_W'(LONG_BLOCK_BYTES);
  assign off_long = off + OFF_W'(LONG_BLOCK_BYTES);

  always_comb begin
    if (!fs_gt) begin
      len = '0;
    end else if (rem_big) begin
      len = LONG_BLOCK_BYTES;
    end else begin
      len = rem[LEN_W-1:0];
    end
  end

  always_comb begin
    plan.blk_num    = blk;
    plan.offset     = off;
    plan.length     = len;
    plan.long_frame = len >= SHORT_BLOCK_BYTES;
    plan.nxt_block  = blk + BLK_W'(1);
    if (!fs_gt) begin
      plan.nxt_offset = off;
    end else if (rem_big) begin
      plan.nxt_offset = off_long;
    end else begin
      plan.nxt_offset = xfer_len;
    end
  end

endmodule

`default_nettype wire

// File: sv/ymodem_sender_controller.sv
// ymodem_sender_controller: sender side of ymodem, one action per reply byte or idle tick
// depends on ysc_pkg and ysc_blk_plan
//
//  channel  dir  tdata                                 tuser
//  in_      in   [7:0] response_byte [8] first_in_chunk [0] kind
//  out_     out  [7:0] block_number [31:8] block_offset [2:0] action
//                [42:32] block_length [43] long_frame
//  cfg_     in   write only: cfg_we, cfg_index, cfg_wdata
//
// one transaction per cycle sustained while out_tready is high
// the input register feeds the phase logic, which loads the result register
// in_tready follows the result register: a stall holds both stages
// rst_n is synchronous, active low; clears phase, counters and valids

`default_nettype none

module ymodem_sender_controller (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output wire logic                           in_tready,
  input  wire logic [ysc_pkg::IN_DATA_W-1:0]  in_tdata,   // response_byte, first_in_chunk
  input  wire logic                           in_tuser,   // kind
  output wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  output wire logic [ysc_pkg::OUT_DATA_W-1:0] out_tdata,  // number, offset, length, long_frame
  output wire logic [2:0]                     out_tuser,  // action
  input  wire logic                           cfg_we,
  input  wire logic [ysc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ysc_pkg::CFG_W-1:0]      cfg_wdata
);
  import ysc_pkg::*;

  typedef enum logic [3:0] {
    PH_WAIT_C      = 4'd0,
    PH_HEADER      = 4'd1,
    PH_DATA        = 4'd2,
    PH_EOT_SENT    = 4'd3,
    PH_EOT_CONFIRM = 4'd4,
    PH_CLOSING     = 4'd5,
    PH_DONE        = 4'd6,
    PH_CANCELLED   = 4'd7,
    PH_GAVE_UP     = 4'd8
  } phase_t;

  // config
  logic               enable_r;
  logic [OFF_W-1:0]   xfer_len_r;
  logic [LIMIT_W-1:0] limit_r;

  // input stage
  logic       s1_valid_r;
  logic       s1_kind_r;
  logic [7:0] s1_byte_r;
  logic       s1_first_r;
  logic       adv;

  // protocol state
  phase_t             phase_r, phase_nxt;
  logic               hdr_acked_r, hdr_acked_nxt;
  logic               eot_acked_r, eot_acked_nxt;
  logic               blk_acked_r, blk_acked_nxt;
  logic [OFF_W-1:0]   next_off_r, next_off_nxt;
  logic [OFF_W-1:0]   last_off_r, last_off_nxt;
  logic [BLK_W-1:0]   next_blk_r, next_blk_nxt;
  logic [LIMIT_W-1:0] idle_r, idle_nxt;
  logic               chunk_r, chunk_nxt;

  // result
  logic             out_valid_r;
  action_t          act_r, act_nxt;
  logic [BLK_W-1:0] res_blk_r, res_blk_nxt;
  logic [OFF_W-1:0] res_off_r, res_off_nxt;
  logic [LEN_W-1:0] res_len_r, res_len_nxt;
  logic             res_long_r, res_long_nxt;

  logic      resend;
  logic      sig;
  blk_plan_t plan;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  assign resend = !(blk_acked_r || (s1_byte_r == BYTE_ACK));

  ysc_blk_plan u_plan (
    .resend      (resend),
    .xfer_len    (xfer_len_r),
    .next_offset (next_off_r),
    .last_offset (last_off_r),
    .next_block  (next_blk_r),
    .plan        (plan)
  );

  always_comb begin
    phase_nxt     = phase_r;
    hdr_acked_nxt = hdr_acked_r;
    eot_acked_nxt = eot_acked_r;
    blk_acked_nxt = blk_acked_r;
    next_off_nxt  = next_off_r;
    last_off_nxt  = last_off_r;
    next_blk_nxt  = next_blk_r;
    idle_nxt      = idle_r;
    chunk_nxt     = chunk_r;
    act_nxt       = ACT_NONE;
    res_blk_nxt   = '0;
    res_off_nxt   = '0;
    res_len_nxt   = '0;
    res_long_nxt  = 1'b0;
    sig           = 1'b0;
    if (phase_r == PH_WAIT_C || phase_r == PH_HEADER || phase_r == PH_DATA ||
        phase_r == PH_EOT_SENT || phase_r == PH_EOT_CONFIRM || phase_r == PH_CLOSING) begin
      if (s1_kind_r) begin
        if (idle_r >= limit_r) begin
          phase_nxt = PH_GAVE_UP;
          act_nxt   = ACT_GAVE_UP;
        end else begin
          idle_nxt = idle_r + LIMIT_W'(1);
        end
      end else if (!enable_r) begin
        chunk_nxt = 1'b0;
      end else if (s1_first_r || chunk_r) begin
        unique case (phase_r)
          PH_WAIT_C: begin
            hdr_acked_nxt = 1'b0;
            eot_acked_nxt = 1'b0;
            if (s1_byte_r == BYTE_C) begin
              phase_nxt = PH_HEADER;
              sig       = 1'b1;
            end else if (s1_byte_r == BYTE_CAN) begin
              phase_nxt = PH_CANCELLED;
              sig       = 1'b1;
            end
          end
          PH_HEADER: begin
            if (s1_byte_r == BYTE_ACK) begin
              hdr_acked_nxt = 1'b1;
            end else if (s1_byte_r == BYTE_C) begin
              if (hdr_acked_r) begin
                hdr_acked_nxt = 1'b0;
                phase_nxt     = PH_DATA;
                sig           = 1'b1;
              end
            end else if (s1_byte_r == BYTE_CAN) begin
              phase_nxt = PH_CANCELLED;
              sig       = 1'b1;
            end
          end
          PH_DATA: begin
            if (s1_byte_r == BYTE_ACK) begin
              blk_acked_nxt = 1'b1;
              sig           = 1'b1;
            end else if (s1_byte_r == BYTE_NAK) begin
              sig = 1'b1;
            end else if (s1_byte_r == BYTE_CAN) begin
              phase_nxt = PH_CANCELLED;
              sig       = 1'b1;
            end
          end
          PH_EOT_SENT: begin
            if (s1_byte_r == BYTE_NAK) begin
              phase_nxt = PH_EOT_CONFIRM;
              sig       = 1'b1;
            end else if (s1_byte_r == BYTE_CAN) begin
              phase_nxt = PH_CANCELLED;
              sig       = 1'b1;
            end
          end
          PH_EOT_CONFIRM: begin
            if (s1_byte_r == BYTE_ACK) begin
              eot_acked_nxt = 1'b1;
            end else if (s1_byte_r == BYTE_C) begin
              if (eot_acked_r) begin
                eot_acked_nxt = 1'b0;
                phase_nxt     = PH_CLOSING;
                sig           = 1'b1;
              end
            end else if (s1_byte_r == BYTE_NAK) begin
              sig = 1'b1;
            end else if (s1_byte_r == BYTE_CAN) begin
              phase_nxt = PH_CANCELLED;
              sig       = 1'b1;
            end
          end
          default: begin
            if (s1_byte_r == BYTE_ACK) begin
              phase_nxt = PH_DONE;
              sig       = 1'b1;
            end else if (s1_byte_r == BYTE_NAK) begin
              sig = 1'b1;
            end else if (s1_byte_r == BYTE_CAN) begin
              phase_nxt = PH_CANCELLED;
              sig       = 1'b1;
            end
          end
        endcase
        chunk_nxt = !sig && (phase_nxt == PH_HEADER || phase_nxt == PH_EOT_CONFIRM);
        if (sig) begin
          idle_nxt = '0;
          unique case (phase_nxt)
            PH_HEADER:      act_nxt = ACT_HEADER;
            PH_DATA: begin
              if (!blk_acked_nxt || next_off_r < xfer_len_r) begin
                blk_acked_nxt = 1'b0;
                act_nxt       = ACT_DATA;
                res_blk_nxt   = plan.blk_num;
                res_off_nxt   = plan.offset;
                res_len_nxt   = plan.length;
                res_long_nxt  = plan.long_frame;
                last_off_nxt  = plan.offset;
                next_off_nxt  = plan.nxt_offset;
                next_blk_nxt  = plan.nxt_block;
              end else begin
                phase_nxt = PH_EOT_SENT;
                act_nxt   = ACT_EOT;
              end
            end
            PH_EOT_CONFIRM: act_nxt = ACT_EOT;
            PH_CLOSING:     act_nxt = ACT_NULL_PKT;
            PH_DONE:        act_nxt = ACT_DONE;
            PH_CANCELLED:   act_nxt = ACT_CANCELLED;
            default:        act_nxt = ACT_NONE;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b1;
      xfer_len_r  <= '0;
      limit_r     <= DEFAULT_TIMEOUT;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_WAIT_C;
      hdr_acked_r <= 1'b0;
      eot_acked_r <= 1'b0;
      blk_acked_r <= 1'b0;
      next_off_r  <= '0;
      last_off_r  <= '0;
      next_blk_r  <= FIRST_BLOCK;
      idle_r      <= '0;
      chunk_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ENABLE:   enable_r   <= cfg_wdata[0];
          REG_XFER_LEN: xfer_len_r <= cfg_wdata[OFF_W-1:0];
          REG_TIMEOUT:  limit_r    <= cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        phase_r     <= phase_nxt;
        hdr_acked_r <= hdr_acked_nxt;
        eot_acked_r <= eot_acked_nxt;
        blk_acked_r <= blk_acked_nxt;
        next_off_r  <= next_off_nxt;
        last_off_r  <= last_off_nxt;
        next_blk_r  <= next_blk_nxt;
        idle_r      <= idle_nxt;
        chunk_r     <= chunk_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_kind_r  <= in_tuser;
      s1_byte_r  <= in_tdata[7:0];
      s1_first_r <= in_tdata[8];
    end
    if (adv) begin
      act_r      <= act_nxt;
      res_blk_r  <= res_blk_nxt;
      res_off_r  <= res_off_nxt;
      res_len_r  <= res_len_nxt;
      res_long_r <= res_long_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = act_r;
  assign out_tdata  = {4'b0000, res_long_r, res_len_r, res_off_r, res_blk_r};

endmodule

`default_nettype wire
